/* rtl/core/pid_antiwindup_controller_defines.svh */
// Assertion helpers for the PID controller checkers.
// Clock and reset names follow the project convention: clock, reset.
`ifndef PID_ANTIWINDUP_CONTROLLER_DEFINES_SVH
`define PID_ANTIWINDUP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define PID_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pid check failed");

// Next-cycle implication, off during reset.
`define PID_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pid check failed");

// What must hold in the cycle after reset.
`define PID_ASSERT_RST(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("pid reset check failed");

`endif

/* rtl/core/pidaw_pkg.sv */
package pidaw_pkg;

   localparam int DW  = 32;   // item and register data
   localparam int AW  = 49;   // multiplier operand, signed
   localparam int MW  = 62;   // multiplier / divider result, signed, |x| <= 2^60
   localparam int UW  = 64;   // wide sums
   localparam int IW  = 48;   // integral
   localparam int RW  = 17;   // ramp factor, unsigned Q1.16
   localparam int CIW = 4;    // csr index width

   localparam logic [RW-1:0] RAMP_START = RW'(6554);
   localparam logic [RW-1:0] RAMP_ONE   = RW'(65536);

   typedef enum logic [1:0] {
      MODE_NONE     = 2'd0,
      MODE_CLAMP    = 2'd1,
      MODE_BACKCALC = 2'd2,
      MODE_COND     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_GAIN_P  = 3'd0,
      CSR_GAIN_I  = 3'd1,
      CSR_GAIN_D  = 3'd2,
      CSR_OUT_MIN = 3'd3,
      CSR_OUT_MAX = 3'd4,
      CSR_MODE    = 3'd5,
      CSR_PARAM_A = 3'd6,
      CSR_PARAM_B = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [DW-1:0] gain_p;
      logic signed [DW-1:0] gain_i;
      logic signed [DW-1:0] gain_d;
      logic signed [DW-1:0] out_min;
      logic signed [DW-1:0] out_max;
      mode_type             windup_mode;
      logic signed [DW-1:0] windup_param_a;
      logic signed [DW-1:0] windup_param_b;
   } cfg_type;

   typedef struct packed {
      logic signed [DW-1:0] measurement;
      logic signed [DW-1:0] setpoint;
      logic [DW-1:0]        time_step;
      logic                 restart;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] drive;
      logic                 clipped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BC,
      ST_EDT,
      ST_BCDT,
      ST_INTUPD,
      ST_INTCLMP,
      ST_DMUL,
      ST_DDIV,
      ST_PMUL,
      ST_IMUL,
      ST_CLIP,
      ST_RAMP,
      ST_DONE
   } state_type;

   function automatic logic signed [DW-1:0] sat32(input logic signed [UW-1:0] v);
      logic signed [UW-1:0] lo;
      logic signed [UW-1:0] hi;
      lo = -(UW'(signed'(65'sh1_0000_0000)) >>> 1);
      hi = UW'(signed'(65'sh7FFF_FFFF));
      if (v < lo) begin
         return {1'b1, {(DW-1){1'b0}}};
      end else if (v > hi) begin
         return {1'b0, {(DW-1){1'b1}}};
      end
      return v[DW-1:0];
   endfunction

   function automatic logic signed [IW-1:0] sat48(input logic signed [UW-1:0] v);
      logic signed [UW-1:0] lo;
      logic signed [UW-1:0] hi;
      hi = UW'(signed'({1'b0, {(IW-1){1'b1}}}));
      lo = -hi - UW'(1);
      if (v < lo) begin
         return {1'b1, {(IW-1){1'b0}}};
      end else if (v > hi) begin
         return {1'b0, {(IW-1){1'b1}}};
      end
      return v[IW-1:0];
   endfunction

endpackage

/* rtl/core/pidaw_mul.sv */
// (a*b)>>16 toward zero, |a| cap 2^48, |b| cap 2^32, result cap 2^60.
// 16-bit slices of |a| against |b|, one slice per cycle, then a finish step.
module pidaw_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [pidaw_pkg::AW-1:0] op_a,
   input  logic signed [pidaw_pkg::AW-1:0] op_b,
   output logic                            done,
   output logic signed [pidaw_pkg::MW-1:0] product
);
   localparam int UAW = 48;
   localparam int UBW = 33;
   localparam int ACW = UAW + UBW;
   localparam int CH  = 16;
   localparam int MGW = ACW - CH;
   localparam logic [MGW-1:0] CAP = MGW'(1) << 60;

   logic [pidaw_pkg::AW-1:0] mag_a, mag_b;
   logic [UAW-1:0]           ua_start;
   logic [UBW-1:0]           ub_start;
   logic [UAW-1:0]           ua_ff, ua_in;
   logic [UBW-1:0]           ub_ff;
   logic [UBW+CH-1:0]        slice_prod;
   logic [ACW-1:0]           acc_ff, acc_in;
   logic [1:0]               cnt_ff;
   logic                     neg_ff, busy_ff, done_ff;
   logic [MGW-1:0]           mag_res, mag_cap;
   logic signed [pidaw_pkg::MW-1:0] product_ff, product_in;

   always_comb begin
      mag_a    = op_a[pidaw_pkg::AW-1] ? pidaw_pkg::AW'(-op_a) : pidaw_pkg::AW'(op_a);
      mag_b    = op_b[pidaw_pkg::AW-1] ? pidaw_pkg::AW'(-op_b) : pidaw_pkg::AW'(op_b);
      // |a| = 2^48 clamps its upper part to all ones
      ua_start = mag_a[UAW] ? {{(UAW-CH){1'b1}}, {CH{1'b0}}} : mag_a[UAW-1:0];
      ub_start = (mag_b > pidaw_pkg::AW'(33'h1_0000_0000)) ? UBW'(33'h1_0000_0000)
                                                            : mag_b[UBW-1:0];
      slice_prod = ua_ff[UAW-1 -: CH] * ub_ff;
      acc_in   = {acc_ff[ACW-CH-1:0], {CH{1'b0}}} + ACW'(slice_prod);
      ua_in    = {ua_ff[UAW-CH-1:0], {CH{1'b0}}};
      mag_res  = acc_ff[ACW-1:CH];
      mag_cap  = (mag_res > CAP) ? CAP : mag_res;
      product_in = neg_ff ? -pidaw_pkg::MW'(mag_cap) : pidaw_pkg::MW'(mag_cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 2'd3);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 2'd3)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= ua_start;
         ub_ff  <= ub_start;
         acc_ff <= '0;
         cnt_ff <= 2'd0;
         neg_ff <= op_a[pidaw_pkg::AW-1] ^ op_b[pidaw_pkg::AW-1];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff != 2'd3) begin
            acc_ff <= acc_in;
            ua_ff  <= ua_in;
         end else begin
            product_ff <= product_in;
         end
      end
   end

   assign done    = done_ff;
   assign product = product_ff;
endmodule

/* rtl/core/pidaw_div.sv */
// (x<<16)/d toward zero, |x| cap 2^47, result cap 2^60.
// Restoring division, one quotient bit per cycle, 64 steps and a finish step.
module pidaw_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [pidaw_pkg::MW-1:0] dividend,
   input  logic [pidaw_pkg::DW-1:0]        divisor,
   output logic                            done,
   output logic signed [pidaw_pkg::MW-1:0] quotient
);
   localparam int QW = 64;
   localparam int XW = 48;
   localparam logic [QW-1:0] CAP = QW'(1) << 60;
   localparam logic [pidaw_pkg::MW-1:0] XCAP = pidaw_pkg::MW'(1) << 47;

   logic [pidaw_pkg::MW-1:0] mag_x;
   logic [XW-1:0]            ux;
   logic [QW-1:0]            quo_ff, quo_in;
   logic [pidaw_pkg::DW-1:0] rem_ff, rem_in, d_ff;
   logic [pidaw_pkg::DW:0]   rem_sh;
   logic                     ge;
   logic [6:0]               cnt_ff;
   logic                     neg_ff, busy_ff, done_ff;
   logic [QW-1:0]            q_cap;
   logic signed [pidaw_pkg::MW-1:0] quotient_ff, quotient_in;

   always_comb begin
      mag_x  = dividend[pidaw_pkg::MW-1] ? pidaw_pkg::MW'(-dividend)
                                         : pidaw_pkg::MW'(dividend);
      ux     = (mag_x > XCAP) ? XW'(XCAP) : mag_x[XW-1:0];
      rem_sh = {rem_ff, quo_ff[QW-1]};
      ge     = rem_sh >= {1'b0, d_ff};
      rem_in = ge ? pidaw_pkg::DW'(rem_sh - {1'b0, d_ff}) : rem_sh[pidaw_pkg::DW-1:0];
      quo_in = {quo_ff[QW-2:0], ge};
      q_cap  = (quo_ff > CAP) ? CAP : quo_ff;
      quotient_in = neg_ff ? -pidaw_pkg::MW'(q_cap) : pidaw_pkg::MW'(q_cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff[6];
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff[6]) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= {ux, 16'd0};
         rem_ff <= '0;
         d_ff   <= divisor;
         cnt_ff <= '0;
         neg_ff <= dividend[pidaw_pkg::MW-1];
      end else if (busy_ff) begin
         if (!cnt_ff[6]) begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 7'd1;
         end else begin
            quotient_ff <= quotient_in;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quotient_ff;
endmodule

/* rtl/core/pidaw_core.sv */
// Sequencer and controller state around the shared multiplier and the divider.
module pidaw_core (
   input  logic               clock,
   input  logic               reset,
   input  pidaw_pkg::cfg_type cfg,
   input  pidaw_pkg::req_type item,
   input  logic               start,
   output logic               busy,
   output logic               res_valid,
   output pidaw_pkg::rsp_type res,
   input  logic               res_take
);
   localparam int DW = pidaw_pkg::DW;
   localparam int AW = pidaw_pkg::AW;
   localparam int UW = pidaw_pkg::UW;
   localparam int IW = pidaw_pkg::IW;
   localparam int RW = pidaw_pkg::RW;

   pidaw_pkg::state_type state_ff, state_in;

   logic signed [DW-1:0] e_ff, bc_ff, perr_ff, pdrive_ff, resid_ff, sat_ff, drive_ff;
   logic [DW-1:0]        dt_ff;
   logic signed [IW-1:0] integ_ff;
   logic [RW-1:0]        ramp_ff;
   logic signed [UW-1:0] acc_ff, u_ff;
   logic signed [pidaw_pkg::MW-1:0] tmp_ff;
   logic                 gate_ff, clipped_ff, issued_ff;

   logic                 need_mul, mul_start, mul_done, div_start, div_done;
   logic signed [AW-1:0] op_a, op_b;
   logic signed [pidaw_pkg::MW-1:0] product, quotient;
   logic signed [DW:0]   diff;
   logic signed [DW-1:0] e_new;
   logic signed [UW-1:0] integ_sum, u_lo, u_clip;
   logic signed [IW-1:0] integ_lim;
   logic [RW:0]          ramp_dbl;
   logic                 is_bc;

   assign is_bc = (cfg.windup_mode == pidaw_pkg::MODE_BACKCALC);

   pidaw_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .done    (mul_done),
      .product (product)
   );

   pidaw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tmp_ff),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pidaw_pkg::ST_IDLE:    if (start) state_in = pidaw_pkg::ST_BC;
         pidaw_pkg::ST_BC:      if (!is_bc || mul_done) state_in = pidaw_pkg::ST_EDT;
         pidaw_pkg::ST_EDT: begin
            if (mul_done) state_in = is_bc ? pidaw_pkg::ST_BCDT : pidaw_pkg::ST_INTUPD;
         end
         pidaw_pkg::ST_BCDT:    if (mul_done) state_in = pidaw_pkg::ST_INTUPD;
         pidaw_pkg::ST_INTUPD:  state_in = pidaw_pkg::ST_INTCLMP;
         pidaw_pkg::ST_INTCLMP: begin
            state_in = (dt_ff != '0) ? pidaw_pkg::ST_DMUL : pidaw_pkg::ST_PMUL;
         end
         pidaw_pkg::ST_DMUL:    if (mul_done) state_in = pidaw_pkg::ST_DDIV;
         pidaw_pkg::ST_DDIV:    if (div_done) state_in = pidaw_pkg::ST_PMUL;
         pidaw_pkg::ST_PMUL:    if (mul_done) state_in = pidaw_pkg::ST_IMUL;
         pidaw_pkg::ST_IMUL:    if (mul_done) state_in = pidaw_pkg::ST_CLIP;
         pidaw_pkg::ST_CLIP:    state_in = pidaw_pkg::ST_RAMP;
         pidaw_pkg::ST_RAMP:    if (mul_done) state_in = pidaw_pkg::ST_DONE;
         pidaw_pkg::ST_DONE:    if (res_take) state_in = pidaw_pkg::ST_IDLE;
         default:               state_in = pidaw_pkg::ST_IDLE;
      endcase
   end

   // unit launch and operand select
   always_comb begin
      need_mul = 1'b0;
      op_a     = '0;
      op_b     = '0;
      unique case (state_ff)
         pidaw_pkg::ST_BC: begin
            need_mul = is_bc;
            op_a = AW'(cfg.windup_param_a);
            op_b = AW'(resid_ff);
         end
         pidaw_pkg::ST_EDT: begin
            need_mul = 1'b1;
            op_a = AW'(e_ff);
            op_b = AW'(signed'({1'b0, dt_ff}));
         end
         pidaw_pkg::ST_BCDT: begin
            need_mul = 1'b1;
            op_a = AW'(bc_ff);
            op_b = AW'(signed'({1'b0, dt_ff}));
         end
         pidaw_pkg::ST_DMUL: begin
            need_mul = 1'b1;
            op_a = AW'(cfg.gain_d);
            op_b = AW'(e_ff) - AW'(perr_ff);
         end
         pidaw_pkg::ST_PMUL: begin
            need_mul = 1'b1;
            op_a = AW'(cfg.gain_p);
            op_b = AW'(e_ff);
         end
         pidaw_pkg::ST_IMUL: begin
            need_mul = 1'b1;
            op_a = AW'(cfg.gain_i);
            op_b = AW'(integ_ff);
         end
         pidaw_pkg::ST_RAMP: begin
            need_mul = 1'b1;
            op_a = AW'(sat_ff);
            op_b = AW'(signed'({1'b0, ramp_ff}));
         end
         default: need_mul = 1'b0;
      endcase
      mul_start = need_mul && !issued_ff;
      div_start = (state_ff == pidaw_pkg::ST_DDIV) && !issued_ff;
      busy      = (state_ff != pidaw_pkg::ST_IDLE);
      res_valid = (state_ff == pidaw_pkg::ST_DONE);
   end

   // datapath arithmetic
   always_comb begin
      diff      = (DW+1)'(item.setpoint) - (DW+1)'(item.measurement);
      e_new     = pidaw_pkg::sat32(UW'(diff));
      integ_sum = UW'(integ_ff) + acc_ff;
      integ_lim = integ_ff;
      if (integ_lim < IW'(cfg.windup_param_a)) integ_lim = IW'(cfg.windup_param_a);
      if (integ_lim > IW'(cfg.windup_param_b)) integ_lim = IW'(cfg.windup_param_b);
      u_lo      = (u_ff < UW'(cfg.out_min)) ? UW'(cfg.out_min) : u_ff;
      u_clip    = (u_lo > UW'(cfg.out_max)) ? UW'(cfg.out_max) : u_lo;
      ramp_dbl  = {ramp_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pidaw_pkg::ST_IDLE;
         issued_ff <= 1'b0;
         integ_ff  <= '0;
         perr_ff   <= '0;
         pdrive_ff <= '0;
         resid_ff  <= '0;
         ramp_ff   <= pidaw_pkg::RAMP_START;
      end else begin
         state_ff <= state_in;
         if (mul_start || div_start) begin
            issued_ff <= 1'b1;
         end else if (mul_done || div_done) begin
            issued_ff <= 1'b0;
         end
         unique case (state_ff)
            pidaw_pkg::ST_IDLE: begin
               if (start && item.restart) begin
                  integ_ff  <= '0;
                  perr_ff   <= '0;
                  pdrive_ff <= '0;
                  ramp_ff   <= pidaw_pkg::RAMP_START;
               end
            end
            pidaw_pkg::ST_INTUPD: begin
               if (gate_ff) integ_ff <= pidaw_pkg::sat48(integ_sum);
            end
            pidaw_pkg::ST_INTCLMP: begin
               if (cfg.windup_mode == pidaw_pkg::MODE_CLAMP) integ_ff <= integ_lim;
            end
            pidaw_pkg::ST_IMUL: begin
               if (mul_done) perr_ff <= e_ff;
            end
            pidaw_pkg::ST_RAMP: begin
               if (mul_done) begin
                  pdrive_ff <= pidaw_pkg::sat32(UW'(product));
                  ramp_ff   <= (ramp_dbl > (RW+1)'(pidaw_pkg::RAMP_ONE))
                               ? pidaw_pkg::RAMP_ONE : ramp_dbl[RW-1:0];
                  if (is_bc) resid_ff <= pidaw_pkg::sat32(UW'(sat_ff) - u_ff);
               end
            end
            default: ;
         endcase
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         pidaw_pkg::ST_IDLE: begin
            e_ff  <= e_new;
            dt_ff <= item.time_step;
         end
         pidaw_pkg::ST_BC: begin
            bc_ff   <= (is_bc && mul_done) ? pidaw_pkg::sat32(UW'(product)) : '0;
            gate_ff <= !((cfg.windup_mode == pidaw_pkg::MODE_COND) &&
                         ((pdrive_ff == cfg.out_min) || (pdrive_ff == cfg.out_max)) &&
                         (e_ff[DW-1] == pdrive_ff[DW-1]));
         end
         pidaw_pkg::ST_EDT:    if (mul_done) acc_ff <= UW'(product);
         pidaw_pkg::ST_BCDT:   if (mul_done) acc_ff <= acc_ff + UW'(product);
         pidaw_pkg::ST_INTUPD: u_ff <= UW'(bc_ff);
         pidaw_pkg::ST_DMUL:   if (mul_done) tmp_ff <= product;
         pidaw_pkg::ST_DDIV:   if (div_done) u_ff <= u_ff + UW'(quotient);
         pidaw_pkg::ST_PMUL:   if (mul_done) u_ff <= u_ff + UW'(product);
         pidaw_pkg::ST_IMUL:   if (mul_done) u_ff <= u_ff + UW'(product);
         pidaw_pkg::ST_CLIP: begin
            sat_ff     <= u_clip[DW-1:0];
            clipped_ff <= (u_clip != u_ff);
         end
         pidaw_pkg::ST_RAMP:   if (mul_done) drive_ff <= pidaw_pkg::sat32(UW'(product));
         default: ;
      endcase
   end

   assign res.drive   = drive_ff;
   assign res.clipped = clipped_ff;
endmodule

/* rtl/core/pid_antiwindup_controller.sv */
// PID controller with anti-windup and start-up ramp, signed Q16.16.
// req channel: one item (measurement, setpoint, time_step, restart) per step.
// rsp channel: one item (drive, clipped) per accepted req item, in order.
// csr channel: register writes by index (gains, limits, windup mode and
//   parameters); always ready, one write per cycle, meant for idle periods.
// Work per item: passes through the shared 16x33 slice multiplier (up to
//   seven passes) and the bit-serial divider for the derivative quotient;
//   back-calculation mode adds multiplier passes, and a zero time_step skips
//   the derivative multiply and divide.
// No new req item is taken before the current one is through; req_ready is
//   low while an item is in work.
// A finished item sits in the rsp output register, so the next req item is
//   taken while rsp_valid waits on rsp_ready.
// If the rsp side stalls with a result still held, the following item waits
//   in its last step until the register frees up.
// Reset (synchronous): registers go to their defaults (limits full scale,
//   gains zero, mode none), integral/error/drive/residue cleared, ramp 0.1.
module pid_antiwindup_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pidaw_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pidaw_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pidaw_pkg::CIW-1:0]     csr_index,
   input  logic [pidaw_pkg::DW-1:0]      csr_wdata
);
   pidaw_pkg::cfg_type cfg_ff;
   pidaw_pkg::rsp_type rsp_data_ff;
   pidaw_pkg::rsp_type core_res;
   logic               rsp_valid_ff;
   logic               core_busy, core_valid, slot_free, req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = !core_busy;
   assign req_fire  = req_valid && req_ready;
   // output register can take a result when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // register file; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.out_min        <= {1'b1, {(pidaw_pkg::DW-1){1'b0}}};
         cfg_ff.out_max        <= {1'b0, {(pidaw_pkg::DW-1){1'b1}}};
         cfg_ff.windup_mode    <= pidaw_pkg::MODE_NONE;
         cfg_ff.windup_param_a <= '0;
         cfg_ff.windup_param_b <= '0;
      end else if (csr_valid && csr_ready && !csr_index[pidaw_pkg::CIW-1]) begin
         unique case (pidaw_pkg::csr_idx_type'(csr_index[pidaw_pkg::CIW-2:0]))
            pidaw_pkg::CSR_GAIN_P:  cfg_ff.gain_p         <= csr_wdata;
            pidaw_pkg::CSR_GAIN_I:  cfg_ff.gain_i         <= csr_wdata;
            pidaw_pkg::CSR_GAIN_D:  cfg_ff.gain_d         <= csr_wdata;
            pidaw_pkg::CSR_OUT_MIN: cfg_ff.out_min        <= csr_wdata;
            pidaw_pkg::CSR_OUT_MAX: cfg_ff.out_max        <= csr_wdata;
            pidaw_pkg::CSR_MODE:    cfg_ff.windup_mode    <= pidaw_pkg::mode_type'(csr_wdata[1:0]);
            pidaw_pkg::CSR_PARAM_A: cfg_ff.windup_param_a <= csr_wdata;
            pidaw_pkg::CSR_PARAM_B: cfg_ff.windup_param_b <= csr_wdata;
            default: ;
         endcase
      end
   end

   pidaw_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item      (req_data),
      .start     (req_fire),
      .busy      (core_busy),
      .res_valid (core_valid),
      .res       (core_res),
      .res_take  (slot_free)
   );

   // rsp output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_valid && slot_free) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

/* rtl/core/pidaw_checker.sv */
`include "pid_antiwindup_controller_defines.svh"

module pidaw_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pidaw_pkg::rsp_type rsp_data
);
   `PID_ASSERT_RST(a_reset_state, !rsp_valid && req_ready)
   `PID_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `PID_ASSERT_NEXT(a_no_instant_result, req_valid && req_ready && !rsp_valid, !rsp_valid)
   `PID_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule

bind pid_antiwindup_controller pidaw_checker u_pidaw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/pid_antiwindup_controller_tb.sv */
`timescale 1ns / 100ps

// Testbench for the PID controller with anti-windup and start-up ramp.
// A bit-accurate predictor runs beside the block: every accepted request
// item is pushed through it and the expected drive/clipped pair is queued.
// A checker pops one expectation per accepted response item.
// Stimulus: a short directed pass over each windup mode and the corner cases,
// then random phases, each with its own register setting.
module pid_antiwindup_controller_tb;

   localparam longint LIM32_MAX = 64'sd2147483647;
   localparam longint LIM32_MIN = -64'sd2147483648;
   localparam longint LIM48_MAX = (64'sd1 <<< 47) - 1;
   localparam longint LIM48_MIN = -(64'sd1 <<< 47);
   localparam bit [63:0] CAP60 = 64'd1 << 60;
   localparam int SETTLE_CYCLES = 200;   // well above the worst-case latency

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   pidaw_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   pidaw_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [pidaw_pkg::CIW-1:0] csr_index;
   logic [pidaw_pkg::DW-1:0] csr_wdata;

   pid_antiwindup_controller dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: register mirror plus controller state
   // ---------------------------------------------------------------------
   pidaw_pkg::cfg_type regs;
   longint integ_acc;
   longint last_err;
   longint last_drive;
   longint bc_residue;
   longint ramp;

   pidaw_pkg::rsp_type drive_queue[$];   // expected responses, oldest first
   int mismatches;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Generous fixed limit; a correct run needs well under a tenth of it.
   initial begin
      #80_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Magnitude of v, capped.
   function automatic bit [63:0] mag_cap(longint v, bit [63:0] cap);
      bit [63:0] m;
      m = (v < 0) ? 64'(-v) : 64'(v);
      return (m > cap) ? cap : m;
   endfunction

   function automatic longint clamp64(longint v, longint lo, longint hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Q16.16 product, truncated toward zero; |a| capped at 2^48, |b| at 2^32.
   function automatic longint q16_mul(longint a, longint b);
      bit neg;
      bit [63:0] ua;
      bit [63:0] ub;
      bit [63:0] hi;
      bit [63:0] lo;
      bit [63:0] m;
      neg = (a < 0) != (b < 0);
      ua = mag_cap(a, 64'd1 << 48);
      ub = mag_cap(b, 64'd1 << 32);
      hi = ua >> 16;
      lo = ua & 64'hFFFF;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      m = hi * ub + ((lo * ub) >> 16);
      if (m > CAP60) m = CAP60;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // (x << 16) / d toward zero, d nonzero.
   function automatic longint q16_div(longint x, bit [31:0] d);
      bit neg;
      bit [63:0] ux;
      bit [63:0] q;
      neg = x < 0;
      ux = mag_cap(x, 64'd1 << 47);
      q = (ux << 16) / {32'd0, d};
      if (q > CAP60) q = CAP60;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic void clear_controller();
      integ_acc = 0;
      last_err = 0;
      last_drive = 0;
      ramp = longint'(pidaw_pkg::RAMP_START);
   endfunction

   // One control step: updates the predictor state, returns the response.
   function automatic pidaw_pkg::rsp_type control_step(pidaw_pkg::req_type r);
      longint err;
      longint bc;
      longint deriv;
      longint u;
      longint sat;
      longint drv;
      longint add;
      longint lo_lim;
      longint hi_lim;
      bit integrate;
      bit at_limit;
      pidaw_pkg::rsp_type res;
      bc = 0;
      deriv = 0;
      integrate = 1'b1;
      lo_lim = longint'(regs.out_min);
      hi_lim = longint'(regs.out_max);
      if (r.restart) clear_controller();
      err = clamp64(longint'(r.setpoint) - longint'(r.measurement), LIM32_MIN, LIM32_MAX);
      if (regs.windup_mode == pidaw_pkg::MODE_BACKCALC)
         bc = clamp64(q16_mul(longint'(regs.windup_param_a), bc_residue),
                      LIM32_MIN, LIM32_MAX);
      if (regs.windup_mode == pidaw_pkg::MODE_COND) begin
         // freeze while pinned at a limit and the error pushes further out
         at_limit = (last_drive == lo_lim) || (last_drive == hi_lim);
         integrate = !(at_limit && ((err < 0) == (last_drive < 0)));
      end
      if (integrate) begin
         add = q16_mul(err, longint'({32'd0, r.time_step}));
         if (regs.windup_mode == pidaw_pkg::MODE_BACKCALC)
            add += q16_mul(bc, longint'({32'd0, r.time_step}));
         integ_acc = clamp64(integ_acc + add, LIM48_MIN, LIM48_MAX);
      end
      if (regs.windup_mode == pidaw_pkg::MODE_CLAMP) begin
         if (integ_acc < longint'(regs.windup_param_a)) integ_acc = regs.windup_param_a;
         if (integ_acc > longint'(regs.windup_param_b)) integ_acc = regs.windup_param_b;
      end
      if (r.time_step != 0)
         deriv = q16_div(q16_mul(longint'(regs.gain_d), err - last_err), r.time_step);
      u = q16_mul(longint'(regs.gain_p), err) + q16_mul(longint'(regs.gain_i), integ_acc)
          + bc + deriv;
      last_err = err;
      sat = u;
      if (sat < lo_lim) sat = lo_lim;
      if (sat > hi_lim) sat = hi_lim;
      if (regs.windup_mode == pidaw_pkg::MODE_BACKCALC)
         bc_residue = clamp64(sat - u, LIM32_MIN, LIM32_MAX);
      drv = clamp64(q16_mul(sat, ramp), LIM32_MIN, LIM32_MAX);
      last_drive = drv;
      ramp = ramp * 2;
      if (ramp > longint'(pidaw_pkg::RAMP_ONE)) ramp = longint'(pidaw_pkg::RAMP_ONE);
      res.drive = drv[31:0];
      res.clipped = (sat != u);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: stall pattern and checker
   // ---------------------------------------------------------------------
   int stall_phase;
   int stall_run;
   initial begin
      rsp_ready = 1'b0;
      stall_phase = 0;
      stall_run = 0;
      forever begin
         @(negedge clock);
         // at the end of each run pick: always ready, coin flip, or long stalls
         if (stall_run == 0) begin
            stall_phase = $urandom_range(0, 2);
            stall_run = 400;
         end
         stall_run--;
         case (stall_phase)
            0: rsp_ready = 1'b1;
            1: rsp_ready = $urandom_range(0, 1);
            default: rsp_ready = ($urandom_range(0, 99) < 3) ? ~rsp_ready : rsp_ready;
         endcase
      end
   end

   always @(posedge clock) begin
      pidaw_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response item: drive=%h clipped=%b",
                        rsp_data.drive, rsp_data.clipped);
         end else begin
            want = drive_queue.pop_front();
            if (rsp_data.drive !== want.drive || rsp_data.clipped !== want.clipped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: drive exp %h got %h, clipped exp %b got %b",
                           want.drive, rsp_data.drive, want.clipped, rsp_data.clipped);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Sends in bursts; valid stays up between items of one burst.
   task automatic send_req(pidaw_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(1, 60);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data = it;
      do @(posedge clock); while (!req_ready);
      drive_queue.push_back(control_step(it));
   endtask

   // Drop valid, drain all expected responses, let the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (drive_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [pidaw_pkg::CIW-1:0] idx, logic [pidaw_pkg::DW-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pidaw_pkg::CIW'(pidaw_pkg::CSR_GAIN_P):  regs.gain_p = value;
         pidaw_pkg::CIW'(pidaw_pkg::CSR_GAIN_I):  regs.gain_i = value;
         pidaw_pkg::CIW'(pidaw_pkg::CSR_GAIN_D):  regs.gain_d = value;
         pidaw_pkg::CIW'(pidaw_pkg::CSR_OUT_MIN): regs.out_min = value;
         pidaw_pkg::CIW'(pidaw_pkg::CSR_OUT_MAX): regs.out_max = value;
         pidaw_pkg::CIW'(pidaw_pkg::CSR_MODE):
            regs.windup_mode = pidaw_pkg::mode_type'(value[1:0]);
         pidaw_pkg::CIW'(pidaw_pkg::CSR_PARAM_A): regs.windup_param_a = value;
         pidaw_pkg::CIW'(pidaw_pkg::CSR_PARAM_B): regs.windup_param_b = value;
         default: ;   // out-of-range index: no register
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(logic [pidaw_pkg::DW-1:0] kp, logic [pidaw_pkg::DW-1:0] ki,
                            logic [pidaw_pkg::DW-1:0] kd, logic [pidaw_pkg::DW-1:0] lo,
                            logic [pidaw_pkg::DW-1:0] hi, pidaw_pkg::mode_type md,
                            logic [pidaw_pkg::DW-1:0] pa, logic [pidaw_pkg::DW-1:0] pb);
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_GAIN_P), kp);
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_GAIN_I), ki);
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_GAIN_D), kd);
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_OUT_MIN), lo);
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_OUT_MAX), hi);
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_MODE), pidaw_pkg::DW'(md));
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_PARAM_A), pa);
      write_csr(pidaw_pkg::CIW'(pidaw_pkg::CSR_PARAM_B), pb);
   endtask

   function automatic pidaw_pkg::req_type make_req(logic [31:0] meas, logic [31:0] sp,
                                                   logic [31:0] dt, logic rst);
      pidaw_pkg::req_type r;
      r.measurement = meas;
      r.setpoint = sp;
      r.time_step = dt;
      r.restart = rst;
      return r;
   endfunction

   // Signed value of modest size, often near the scale of a real loop.
   function automatic logic [31:0] rand_q(int bits);
      logic [31:0] v;
      v = $urandom;
      return 32'(signed'(v) >>> (32 - bits));
   endfunction

   function automatic pidaw_pkg::req_type rand_req();
      logic [31:0] meas;
      logic [31:0] sp;
      logic [31:0] dt;
      int sel;
      sel = $urandom_range(0, 9);
      meas = (sel == 0) ? $urandom : rand_q(22);
      sp = (sel == 1) ? $urandom : rand_q(22);
      case ($urandom_range(0, 7))
         0: dt = 32'd0;
         1: dt = $urandom;
         2: dt = 32'hFFFF_FFFF;
         default: dt = $urandom_range(1, 32'h0002_0000);
      endcase
      return make_req(meas, sp, dt, $urandom_range(0, 99) < 4);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset defaults: zero gains give zero drive, nothing clipped.
   task automatic test_reset_defaults();
      send_req(make_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
      send_req(make_req(32'h0001_0000, 32'h0005_0000, 32'h0000_1000, 1'b0));
      drain();
   endtask

   // Each windup mode with error extremes, zero and full time step, restart.
   task automatic test_directed_modes();
      for (int m = 0; m < 4; m++) begin
         write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                   32'hFF9C_0000, 32'h0064_0000, pidaw_pkg::mode_type'(m),
                   (m == pidaw_pkg::MODE_BACKCALC) ? 32'h0000_8000 : 32'hFFF6_0000,
                   32'h000A_0000);
         send_req(make_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0));
         send_req(make_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
         send_req(make_req(32'h0000_0000, 32'h0003_0000, 32'h0000_0000, 1'b0));
         send_req(make_req(32'h0002_0000, 32'h0001_0000, 32'h0000_0001, 1'b1));
         send_req(make_req(32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 1'b0));
         drain();
      end
   endtask

   // Inverted limits and a clamp window with lower bound above upper.
   task automatic test_inverted_limits();
      write_all(32'h0002_0000, 32'h0001_0000, 32'h0000_0000,
                32'h0010_0000, 32'hFFF0_0000, pidaw_pkg::MODE_CLAMP,
                32'h0005_0000, 32'hFFFB_0000);
      send_req(make_req(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1));
      send_req(make_req(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b0));
      drain();
   endtask

   // Writes to indexes past the register file must change nothing.
   task automatic test_bad_index();
      write_csr({1'b1, pidaw_pkg::CSR_GAIN_P}, 32'h1234_5678);
      write_csr({1'b1, pidaw_pkg::CSR_PARAM_B}, 32'hFFFF_FFFF);
      write_csr({1'b1, pidaw_pkg::CSR_MODE}, 32'h0000_0002);
      send_req(make_req(32'h0003_0000, 32'h0000_0000, 32'h0000_4000, 1'b0));
      drain();
   endtask

   // Random phases; mode cycles, some phases at full-scale settings.
   task automatic test_random_phases();
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] pa;
      logic [31:0] pb;
      bit wide;
      for (int ph = 0; ph < 16; ph++) begin
         wide = (ph % 5) == 4;
         case ($urandom_range(0, 3))
            0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
            1: begin lo = $urandom; hi = $urandom; end
            default: begin lo = -rand_q(24) & 32'hFFFF_FFFF; hi = rand_q(24); end
         endcase
         if (ph % 4 == pidaw_pkg::MODE_BACKCALC) pa = rand_q(18);
         else pa = wide ? $urandom : rand_q(28);
         pb = wide ? $urandom : rand_q(28);
         write_all(wide ? $urandom : rand_q(20), wide ? $urandom : rand_q(18),
                   wide ? $urandom : rand_q(16), lo, hi,
                   pidaw_pkg::mode_type'(ph % 4), pa, pb);
         for (int n = 0; n < 125; n++) send_req(rand_req());
         drain();
      end
      // extremes of the registers
      write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, pidaw_pkg::MODE_BACKCALC,
                32'h7FFF_FFFF, 32'h8000_0000);
      for (int n = 0; n < 40; n++) send_req(rand_req());
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      burst_left = 0;
      regs.gain_p = '0;
      regs.gain_i = '0;
      regs.gain_d = '0;
      regs.out_min = 32'h8000_0000;
      regs.out_max = 32'h7FFF_FFFF;
      regs.windup_mode = pidaw_pkg::MODE_NONE;
      regs.windup_param_a = '0;
      regs.windup_param_b = '0;
      bc_residue = 0;
      clear_controller();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_modes();
      test_inverted_limits();
      test_bad_index();
      test_random_phases();

      if (mismatches == 0 && drive_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
